// ----- hw/rtl/cbd_pkg.sv -----
package cbd_pkg;

    // Work RAM size in bytes; mirrored across 0x0000-0x1FFF
    localparam int RAM_BYTES = 2048;
    localparam int RAM_AW    = $clog2(RAM_BYTES);

    // Mirror reduction: 13-bit offset, at least 256 bytes of RAM, so the quotient fits 5 bits
    localparam int SLOT_QBITS = 5;
    localparam int SLOT_W     = 18;

    // Action codes
    localparam logic [2:0] ACT_READ   = 3'd0;
    localparam logic [2:0] ACT_PEEK   = 3'd1;
    localparam logic [2:0] ACT_WRITE  = 3'd2;
    localparam logic [2:0] ACT_SPRITE = 3'd3;
    localparam logic [2:0] ACT_SAMPLE = 3'd4;

    // Target codes
    localparam logic [2:0] TGT_NONE   = 3'd0;
    localparam logic [2:0] TGT_RAM    = 3'd1;
    localparam logic [2:0] TGT_VIDEO  = 3'd2;
    localparam logic [2:0] TGT_SPRITE = 3'd3;
    localparam logic [2:0] TGT_AUDIO  = 3'd4;
    localparam logic [2:0] TGT_PAD1   = 3'd5;
    localparam logic [2:0] TGT_PAD2   = 3'd6;
    localparam logic [2:0] TGT_CART   = 3'd7;

    // Address map
    localparam logic [15:0] ADDR_RAM_END      = 16'h1FFF;
    localparam logic [15:0] ADDR_VIDEO_END    = 16'h3FFF;
    localparam logic [15:0] ADDR_APU_FIRST    = 16'h4000;
    localparam logic [15:0] ADDR_SPRITE_PORT  = 16'h4014;
    localparam logic [15:0] ADDR_AUDIO_STATUS = 16'h4015;
    localparam logic [15:0] ADDR_PAD1         = 16'h4016;
    localparam logic [15:0] ADDR_PAD2         = 16'h4017;
    localparam logic [15:0] ADDR_CART_WR      = 16'h5FFF;
    localparam logic [15:0] ADDR_CART_RD      = 16'h6000;

    // Open-bus merge masks
    localparam logic [7:0] OB_AUDIO_MASK  = 8'h20;
    localparam logic [7:0] DEV_AUDIO_MASK = 8'hDF;
    localparam logic [7:0] OB_PAD_MASK    = 8'hE0;
    localparam logic [7:0] DEV_PAD_MASK   = 8'h1F;

    // Source of the read byte
    typedef enum logic [2:0] {
        RSEL_ZERO  = 3'd0,
        RSEL_RAM   = 3'd1,
        RSEL_DEV   = 3'd2,
        RSEL_AUDIO = 3'd3,
        RSEL_PAD   = 3'd4
    } rsel_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        cycle_odd;
        logic [7:0]  device_data;
        logic [7:0]  oam_base;
    } cbd_in_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [2:0]  target;
        logic [15:0] access_address;
        logic        access_is_write;
        logic        device_strobe;
        logic        oam_write;
        logic [7:0]  oam_index;
        logic [7:0]  oam_value;
        logic        dmc_fetch;
        logic        dmc_fetch_get;
        logic        oam_dma_busy;
        logic        dmc_dma_busy;
    } cbd_out_t;

    // Decoded item handed from decode to resolve
    typedef struct packed {
        rsel_t       rsel;
        logic [2:0]  target;
        logic [15:0] access_address;
        logic        access_is_write;
        logic        device_strobe;
        logic        oam_write;
        logic [7:0]  oam_index;
        logic        dmc_fetch;
        logic        dmc_fetch_get;
        logic        oam_dma_busy;
        logic        dmc_dma_busy;
        logic [7:0]  device_data;
        logic [7:0]  write_data;
        logic        ob_from_read;
        logic        ob_from_write;
        logic        latch_load;
    } cbd_op_t;

    // RAM slot of a mirrored address: restoring reduction, one compare-subtract per step
    function automatic logic [RAM_AW-1:0] ram_slot(input logic [15:0] a);
        logic [SLOT_W-1:0] r;
        logic [SLOT_W-1:0] d;
        r = {{(SLOT_W-13){1'b0}}, a[12:0]};
        for (int i = SLOT_QBITS - 1; i >= 0; i--)
        begin
            d = SLOT_W'(RAM_BYTES) << i;
            if (r >= d)
            begin
                r = r - d;
            end
        end
        return r[RAM_AW-1:0];
    endfunction

endpackage

// ----- hw/rtl/cbd_if.sv -----
// Request channel: one bus access or DMA tick per item
interface cbd_in_if;
    logic              valid;
    logic              ready;
    cbd_pkg::cbd_in_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// Result channel: one result item per request item
interface cbd_out_if;
    logic              valid;
    logic              ready;
    cbd_pkg::cbd_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/cbd_ram.sv -----
// Simple dual-port RAM, registered read
module cbd_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/cbd_decode.sv -----
// Decode stage: address decode, DMA sequencing, RAM port control, clearing pass
module cbd_decode (
    input  logic                    clk,
    input  logic                    rst_n,
    cbd_in_if.sink                  req,
    input  logic                    s1_take,
    output logic                    s1_valid,
    output cbd_pkg::cbd_op_t        s1_op,
    output logic                    ram_we,
    output logic [cbd_pkg::RAM_AW-1:0] ram_waddr,
    output logic [7:0]              ram_wdata,
    output logic                    ram_re,
    output logic [cbd_pkg::RAM_AW-1:0] ram_raddr
);

    cbd_pkg::cbd_in_t p;
    cbd_pkg::cbd_op_t op;
    logic             accept;

    // Control state
    logic [15:0] last_read_reg, last_read_next;
    logic [7:0]  dma_page_reg, dma_page_next;
    logic [7:0]  dma_count_reg, dma_count_next;
    logic        sprite_active_reg, sprite_active_next;
    logic        sample_active_reg, sample_active_next;
    logic        halt_pending_reg, halt_pending_next;

    // Clearing pass
    logic                       clearing_reg, clearing_next;
    logic [cbd_pkg::RAM_AW-1:0] clr_cnt_reg, clr_cnt_next;

    // Stage register
    logic             s1_valid_reg, s1_valid_next;
    cbd_pkg::cbd_op_t s1_op_reg;

    // Read request assembled by the action decode
    logic        do_read;
    logic        rd_peek;
    logic [15:0] rd_addr;
    logic        rd_ext;
    logic        wr_ext;

    assign p         = req.payload;
    assign req.ready = !clearing_reg && (!s1_valid_reg || s1_take);
    assign accept    = req.valid && req.ready;
    assign s1_valid  = s1_valid_reg;
    assign s1_op     = s1_op_reg;

    // Action decode and state update
    always_comb
    begin
        op                 = '0;
        op.rsel            = cbd_pkg::RSEL_ZERO;
        last_read_next     = last_read_reg;
        dma_page_next      = dma_page_reg;
        dma_count_next     = dma_count_reg;
        sprite_active_next = sprite_active_reg;
        sample_active_next = sample_active_reg;
        halt_pending_next  = halt_pending_reg;
        do_read            = 1'b0;
        rd_peek            = 1'b0;
        rd_addr            = '0;
        rd_ext             = 1'b0;
        wr_ext             = 1'b0;
        ram_we             = 1'b0;
        ram_waddr          = clr_cnt_reg;
        ram_wdata          = '0;
        ram_re             = 1'b0;
        ram_raddr          = '0;

        if (accept)
        begin
            op.device_data = p.device_data;
            op.write_data  = p.write_data;
            case (p.action)
                cbd_pkg::ACT_READ, cbd_pkg::ACT_PEEK:
                begin
                    do_read = 1'b1;
                    rd_peek = (p.action == cbd_pkg::ACT_PEEK);
                    rd_addr = p.address;
                end
                cbd_pkg::ACT_WRITE:
                begin
                    op.access_address = p.address;
                    op.ob_from_write  = 1'b1;
                    if (p.address <= cbd_pkg::ADDR_RAM_END)
                    begin
                        op.target = cbd_pkg::TGT_RAM;
                        ram_we    = 1'b1;
                        ram_waddr = cbd_pkg::ram_slot(p.address);
                        ram_wdata = p.write_data;
                    end
                    else if (p.address <= cbd_pkg::ADDR_VIDEO_END)
                    begin
                        op.target = cbd_pkg::TGT_VIDEO;
                        wr_ext    = 1'b1;
                    end
                    else if (p.address == cbd_pkg::ADDR_SPRITE_PORT)
                    begin
                        op.target          = cbd_pkg::TGT_SPRITE;
                        dma_page_next      = p.write_data;
                        dma_count_next     = '0;
                        sprite_active_next = 1'b1;
                        halt_pending_next  = 1'b1;
                    end
                    else if (p.address == cbd_pkg::ADDR_PAD1)
                    begin
                        op.target = cbd_pkg::TGT_PAD1;
                        wr_ext    = 1'b1;
                    end
                    else if (p.address >= cbd_pkg::ADDR_APU_FIRST &&
                             p.address <= cbd_pkg::ADDR_PAD2)
                    begin
                        op.target = cbd_pkg::TGT_AUDIO;
                        wr_ext    = 1'b1;
                        // sample channel enable raises the DMA flag
                        if (p.address == cbd_pkg::ADDR_AUDIO_STATUS && |p.write_data[7:4])
                        begin
                            sample_active_next = 1'b1;
                            halt_pending_next  = 1'b1;
                        end
                    end
                    else if (p.address >= cbd_pkg::ADDR_CART_WR)
                    begin
                        op.target = cbd_pkg::TGT_CART;
                        wr_ext    = 1'b1;
                    end
                    op.access_is_write = wr_ext;
                    op.device_strobe   = wr_ext;
                end
                cbd_pkg::ACT_SPRITE:
                begin
                    if (sprite_active_reg)
                    begin
                        if (halt_pending_reg)
                        begin
                            // alignment: put clears the halt, get repeats the last read
                            if (p.cycle_odd)
                            begin
                                halt_pending_next = 1'b0;
                            end
                            else
                            begin
                                do_read = 1'b1;
                                rd_addr = last_read_reg;
                            end
                        end
                        else if (!p.cycle_odd)
                        begin
                            do_read       = 1'b1;
                            rd_addr       = {dma_page_reg, dma_count_reg};
                            op.latch_load = 1'b1;
                        end
                        else
                        begin
                            op.oam_write   = 1'b1;
                            op.oam_index   = p.oam_base + dma_count_reg;
                            dma_count_next = dma_count_reg + 8'd1;
                            if (dma_count_reg == 8'hFF)
                            begin
                                sprite_active_next = 1'b0;
                                halt_pending_next  = 1'b1;
                            end
                        end
                    end
                end
                cbd_pkg::ACT_SAMPLE:
                begin
                    if (sample_active_reg)
                    begin
                        if (halt_pending_reg)
                        begin
                            if (p.cycle_odd)
                            begin
                                halt_pending_next = 1'b0;
                            end
                            else
                            begin
                                do_read = 1'b1;
                                rd_addr = last_read_reg;
                            end
                        end
                        else
                        begin
                            op.dmc_fetch     = 1'b1;
                            op.dmc_fetch_get = !p.cycle_odd;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // Read decode, shared by reads, peeks, DMA gets and dummy reads
            if (do_read)
            begin
                op.access_address = rd_addr;
                if (rd_addr <= cbd_pkg::ADDR_RAM_END)
                begin
                    op.rsel   = cbd_pkg::RSEL_RAM;
                    op.target = cbd_pkg::TGT_RAM;
                    ram_re    = 1'b1;
                    ram_raddr = cbd_pkg::ram_slot(rd_addr);
                end
                else if (rd_addr <= cbd_pkg::ADDR_VIDEO_END)
                begin
                    op.rsel   = cbd_pkg::RSEL_DEV;
                    op.target = cbd_pkg::TGT_VIDEO;
                    rd_ext    = 1'b1;
                end
                else if (rd_addr == cbd_pkg::ADDR_SPRITE_PORT)
                begin
                    op.rsel   = cbd_pkg::RSEL_DEV;
                    op.target = cbd_pkg::TGT_SPRITE;
                    rd_ext    = 1'b1;
                end
                else if (rd_addr == cbd_pkg::ADDR_AUDIO_STATUS)
                begin
                    op.rsel   = cbd_pkg::RSEL_AUDIO;
                    op.target = cbd_pkg::TGT_AUDIO;
                    rd_ext    = 1'b1;
                end
                else if (rd_addr == cbd_pkg::ADDR_PAD1)
                begin
                    op.rsel   = cbd_pkg::RSEL_PAD;
                    op.target = cbd_pkg::TGT_PAD1;
                    rd_ext    = 1'b1;
                end
                else if (rd_addr == cbd_pkg::ADDR_PAD2)
                begin
                    op.rsel   = cbd_pkg::RSEL_PAD;
                    op.target = cbd_pkg::TGT_PAD2;
                    rd_ext    = 1'b1;
                end
                else if (rd_addr >= cbd_pkg::ADDR_CART_RD)
                begin
                    op.rsel   = cbd_pkg::RSEL_DEV;
                    op.target = cbd_pkg::TGT_CART;
                    rd_ext    = 1'b1;
                end
                op.device_strobe = rd_ext && !rd_peek;
                op.ob_from_read  = !rd_peek;
                if (!rd_peek)
                begin
                    last_read_next = rd_addr;
                end
            end
        end

        // Clearing pass owns the write port; no item is taken meanwhile
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end

        op.oam_dma_busy = sprite_active_next;
        op.dmc_dma_busy = sample_active_next;
    end

    // Clearing counter
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == cbd_pkg::RAM_AW'(cbd_pkg::RAM_BYTES - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    // Stage occupancy
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_take)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_read_reg     <= '0;
            dma_page_reg      <= '0;
            dma_count_reg     <= '0;
            sprite_active_reg <= 1'b0;
            sample_active_reg <= 1'b0;
            halt_pending_reg  <= 1'b0;
            clearing_reg      <= 1'b1;
            clr_cnt_reg       <= '0;
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            last_read_reg     <= last_read_next;
            dma_page_reg      <= dma_page_next;
            dma_count_reg     <= dma_count_next;
            sprite_active_reg <= sprite_active_next;
            sample_active_reg <= sample_active_next;
            halt_pending_reg  <= halt_pending_next;
            clearing_reg      <= clearing_next;
            clr_cnt_reg       <= clr_cnt_next;
            s1_valid_reg      <= s1_valid_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg <= op;
        end
    end

    // No item enters while the RAM is being cleared
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !req.ready)
        else $error("item taken during RAM clearing pass");

    // A stalled stage keeps its item
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_take |=> s1_valid_reg && $stable(s1_op_reg))
        else $error("stage item lost or changed while stalled");

    // End of a sprite transfer leaves a halt pending
    a_sprite_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(sprite_active_reg) |-> halt_pending_reg)
        else $error("sprite transfer ended without pending halt");

    // A single item never both reads and writes the RAM
    a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("RAM read and write in the same cycle");

endmodule

// ----- hw/rtl/cbd_resolve.sv -----
// Resolve stage: read byte selection, open-bus and DMA latch, output register
module cbd_resolve (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s1_valid,
    input  cbd_pkg::cbd_op_t s1_op,
    input  logic [7:0]       ram_rdata,
    output logic             s1_take,
    cbd_out_if.source        rsp
);

    logic [7:0]        open_bus_reg, open_bus_next;
    logic [7:0]        dma_latch_reg, dma_latch_next;
    logic              out_valid_reg, out_valid_next;
    cbd_pkg::cbd_out_t out_reg;
    cbd_pkg::cbd_out_t out_next;
    logic [7:0]        rd_byte;

    assign s1_take     = s1_valid && (!out_valid_reg || rsp.ready);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // Read byte with open-bus merge
    always_comb
    begin
        case (s1_op.rsel)
            cbd_pkg::RSEL_RAM:   rd_byte = ram_rdata;
            cbd_pkg::RSEL_DEV:   rd_byte = s1_op.device_data;
            cbd_pkg::RSEL_AUDIO: rd_byte = (open_bus_reg & cbd_pkg::OB_AUDIO_MASK) |
                                           (s1_op.device_data & cbd_pkg::DEV_AUDIO_MASK);
            cbd_pkg::RSEL_PAD:   rd_byte = (open_bus_reg & cbd_pkg::OB_PAD_MASK) |
                                           (s1_op.device_data & cbd_pkg::DEV_PAD_MASK);
            default:             rd_byte = '0;
        endcase
    end

    // Result item and state updates
    always_comb
    begin
        out_next.read_data       = rd_byte;
        out_next.target          = s1_op.target;
        out_next.access_address  = s1_op.access_address;
        out_next.access_is_write = s1_op.access_is_write;
        out_next.device_strobe   = s1_op.device_strobe;
        out_next.oam_write       = s1_op.oam_write;
        out_next.oam_index       = s1_op.oam_index;
        out_next.oam_value       = s1_op.oam_write ? dma_latch_reg : 8'd0;
        out_next.dmc_fetch       = s1_op.dmc_fetch;
        out_next.dmc_fetch_get   = s1_op.dmc_fetch_get;
        out_next.oam_dma_busy    = s1_op.oam_dma_busy;
        out_next.dmc_dma_busy    = s1_op.dmc_dma_busy;

        open_bus_next  = open_bus_reg;
        dma_latch_next = dma_latch_reg;
        if (s1_take)
        begin
            if (s1_op.ob_from_read)
            begin
                open_bus_next = rd_byte;
            end
            else if (s1_op.ob_from_write)
            begin
                open_bus_next = s1_op.write_data;
            end
            if (s1_op.latch_load)
            begin
                dma_latch_next = rd_byte;
            end
        end

        out_valid_next = out_valid_reg;
        if (s1_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_bus_reg  <= '0;
            dma_latch_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            open_bus_reg  <= open_bus_next;
            dma_latch_reg <= dma_latch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- hw/rtl/cpu_bus_decoder_with_oam_dma.sv -----
// Path: decode stage register (with the RAM read), then the resolve output register.
// Throughput: one item per clock unless the result side stalls; the RAM takes the write
// of one item and the read of the next in consecutive cycles, and the output register
// frees the request side. Reset: asynchronous, active low; clears all control state,
// then a clearing pass zeroes all RAM_BYTES (2048) bytes of work RAM, req.ready held low.
module cpu_bus_decoder_with_oam_dma (
    input  logic      clk,
    input  logic      rst_n,
    cbd_in_if.sink    req,
    cbd_out_if.source rsp
);

    logic                       s1_valid;
    logic                       s1_take;
    cbd_pkg::cbd_op_t           s1_op;
    logic                       ram_we;
    logic [cbd_pkg::RAM_AW-1:0] ram_waddr;
    logic [7:0]                 ram_wdata;
    logic                       ram_re;
    logic [cbd_pkg::RAM_AW-1:0] ram_raddr;
    logic [7:0]                 ram_rdata;

    cbd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .s1_take   (s1_take),
        .s1_valid  (s1_valid),
        .s1_op     (s1_op),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    cbd_ram #(
        .DEPTH (cbd_pkg::RAM_BYTES),
        .WIDTH (8)
    ) u_work_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cbd_resolve u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_op     (s1_op),
        .ram_rdata (ram_rdata),
        .s1_take   (s1_take),
        .rsp       (rsp)
    );

endmodule

// ----- tb/tb.sv -----
module tb;

    import cbd_pkg::*;

    // Action code with no meaning to the block
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    localparam int RANDOM_ITEMS = 1650;

    typedef struct {
        cbd_in_t  stim;
        bit       typed;
        cbd_out_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    cbd_in_if  req ();
    cbd_out_if rsp ();

    cpu_bus_decoder_with_oam_dma u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bus state as the block should hold it
    logic [7:0]  ram_image [0:RAM_BYTES-1];
    logic [7:0]  bus_hold;
    logic [15:0] last_rd_addr;
    logic [7:0]  copy_page;
    logic [7:0]  copy_count;
    logic [7:0]  copy_byte;
    bit          sprite_on;
    bit          sample_on;
    bit          halt_wait;

    cbd_out_t    pending_results [$];
    dir_row_t    dir_rows [$];
    int          n_errors;
    int          n_results;
    int          n_counted;
    bit          tx_quiet;
    bit          rx_quiet;
    bit          rx_hold_req;

    function automatic int unsigned mirror_slot(input logic [15:0] a);
        return (a & ADDR_RAM_END) % RAM_BYTES;
    endfunction

    // One bus read; a peek leaves the open bus and last address alone
    function automatic cbd_out_t bus_fetch(input logic [15:0] a, input bit peek,
                                           input logic [7:0] dev);
        cbd_out_t o;
        bit       ext;
        o   = '0;
        ext = 1'b1;
        if (a <= ADDR_RAM_END)
        begin
            o.read_data = ram_image[mirror_slot(a)];
            o.target    = TGT_RAM;
            ext         = 1'b0;
        end
        else if (a <= ADDR_VIDEO_END)
        begin
            o.read_data = dev;
            o.target    = TGT_VIDEO;
        end
        else if (a == ADDR_SPRITE_PORT)
        begin
            o.read_data = dev;
            o.target    = TGT_SPRITE;
        end
        else if (a == ADDR_AUDIO_STATUS)
        begin
            o.read_data = (bus_hold & OB_AUDIO_MASK) | (dev & DEV_AUDIO_MASK);
            o.target    = TGT_AUDIO;
        end
        else if (a == ADDR_PAD1 || a == ADDR_PAD2)
        begin
            o.read_data = (bus_hold & OB_PAD_MASK) | (dev & DEV_PAD_MASK);
            o.target    = (a == ADDR_PAD1) ? TGT_PAD1 : TGT_PAD2;
        end
        else if (a >= ADDR_CART_RD)
        begin
            o.read_data = dev;
            o.target    = TGT_CART;
        end
        else
        begin
            ext = 1'b0;
        end
        o.access_address = a;
        o.device_strobe  = ext && !peek;
        if (!peek)
        begin
            bus_hold     = o.read_data;
            last_rd_addr = a;
        end
        return o;
    endfunction

    // Result of one item, advancing the bus state
    function automatic cbd_out_t next_bus_result(input cbd_in_t it);
        cbd_out_t o;
        bit       ext;
        bit       put;
        o   = '0;
        put = it.cycle_odd;
        case (it.action)
            ACT_READ, ACT_PEEK:
            begin
                o = bus_fetch(it.address, it.action == ACT_PEEK, it.device_data);
            end
            ACT_WRITE:
            begin
                ext      = 1'b1;
                bus_hold = it.write_data;
                if (it.address <= ADDR_RAM_END)
                begin
                    ram_image[mirror_slot(it.address)] = it.write_data;
                    o.target = TGT_RAM;
                    ext      = 1'b0;
                end
                else if (it.address <= ADDR_VIDEO_END)
                begin
                    o.target = TGT_VIDEO;
                end
                else if (it.address == ADDR_SPRITE_PORT)
                begin
                    copy_page  = it.write_data;
                    copy_count = '0;
                    sprite_on  = 1'b1;
                    halt_wait  = 1'b1;
                    o.target   = TGT_SPRITE;
                    ext        = 1'b0;
                end
                else if (it.address == ADDR_PAD1)
                begin
                    o.target = TGT_PAD1;
                end
                else if (it.address >= ADDR_APU_FIRST && it.address <= ADDR_PAD2)
                begin
                    // any of the upper four bits enables the sample channel
                    if (it.address == ADDR_AUDIO_STATUS && it.write_data[7:4] != 4'h0)
                    begin
                        sample_on = 1'b1;
                        halt_wait = 1'b1;
                    end
                    o.target = TGT_AUDIO;
                end
                else if (it.address >= ADDR_CART_WR)
                begin
                    o.target = TGT_CART;
                end
                else
                begin
                    ext = 1'b0;
                end
                o.access_address  = it.address;
                o.access_is_write = ext;
                o.device_strobe   = ext;
            end
            ACT_SPRITE:
            begin
                if (sprite_on)
                begin
                    if (halt_wait)
                    begin
                        if (put)
                            halt_wait = 1'b0;
                        else
                            o = bus_fetch(last_rd_addr, 1'b0, it.device_data);
                    end
                    else if (!put)
                    begin
                        o = bus_fetch({copy_page, copy_count}, 1'b0, it.device_data);
                        copy_byte = o.read_data;
                    end
                    else
                    begin
                        o.oam_write = 1'b1;
                        o.oam_index = it.oam_base + copy_count;
                        o.oam_value = copy_byte;
                        copy_count  = copy_count + 8'd1;
                        if (copy_count == 8'd0)
                        begin
                            sprite_on = 1'b0;
                            halt_wait = 1'b1;
                        end
                    end
                end
            end
            ACT_SAMPLE:
            begin
                if (sample_on)
                begin
                    if (halt_wait)
                    begin
                        if (put)
                            halt_wait = 1'b0;
                        else
                            o = bus_fetch(last_rd_addr, 1'b0, it.device_data);
                    end
                    else
                    begin
                        o.dmc_fetch     = 1'b1;
                        o.dmc_fetch_get = !put;
                    end
                end
            end
            default:
            begin
            end
        endcase
        o.oam_dma_busy = sprite_on;
        o.dmc_dma_busy = sample_on;
        return o;
    endfunction

    function automatic cbd_in_t mk_item(input logic [2:0] act, input logic [15:0] addr,
                                        input logic [7:0] wd, input logic odd,
                                        input logic [7:0] dev, input logic [7:0] base);
        cbd_in_t it;
        it.action      = act;
        it.address     = addr;
        it.write_data  = wd;
        it.cycle_odd   = odd;
        it.device_data = dev;
        it.oam_base    = base;
        return it;
    endfunction

    // Plain bus result with no DMA activity and both flags low
    function automatic cbd_out_t bus_res(input logic [7:0] rd, input logic [2:0] tgt,
                                         input logic [15:0] addr, input logic wr,
                                         input logic stb);
        cbd_out_t o;
        o                 = '0;
        o.read_data       = rd;
        o.target          = tgt;
        o.access_address  = addr;
        o.access_is_write = wr;
        o.device_strobe   = stb;
        return o;
    endfunction

    // Address spread over the decode boundaries, with full-range draws
    function automatic logic [15:0] rand_addr();
        logic [15:0] a;
        case ($urandom_range(0, 5))
            0:       a = 16'($urandom_range(0, 16'h1FFF));
            1:       a = 16'(16'h2000 + $urandom_range(0, 16'h1FFF));
            2:       a = 16'(16'h4000 + $urandom_range(0, 31));
            3:       a = 16'(16'h5FF0 + $urandom_range(0, 31));
            default: a = 16'($urandom);
        endcase
        return a;
    endfunction

    function automatic cbd_in_t rand_item(input logic [2:0] act);
        return mk_item(act, rand_addr(), 8'($urandom), 1'($urandom), 8'($urandom),
                       8'($urandom));
    endfunction

    task automatic report(input string msg);
        $display("ERROR: %s", msg);
        n_errors++;
    endtask

    task automatic cmp_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
        if (got !== want)
            report($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                             n_results, name, got, want));
    endtask

    // Offer one item after a random gap; predict once it is taken
    task automatic send_item(input cbd_in_t it, input bit typed, input cbd_out_t want);
        int       gap;
        bit       ignored;
        cbd_out_t pred;
        if ($urandom_range(0, 63) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid   <= 1'b1;
        req.payload <= it;
        do
            @(posedge clk);
        while (!req.ready);
        ignored = (it.action > ACT_SAMPLE) || (it.action == ACT_SPRITE && !sprite_on)
                  || (it.action == ACT_SAMPLE && !sample_on);
        pred = next_bus_result(it);
        pending_results.push_back(typed ? want : pred);
        if (!ignored)
            n_counted++;
        @(negedge clk);
    endtask

    // Hold the request side until every result is back
    task automatic drain();
        req.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
    endtask

    // Sprite copy: the 0x4014 write, then ticks of mostly alternating parity, with random items mixed in
    task automatic sprite_copy(input bit whole);
        logic [7:0] page;
        logic [7:0] base;
        logic       odd;
        int         ticks;
        int         n;
        page  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 8'h1F)) : 8'($urandom);
        base  = 8'($urandom);
        odd   = 1'($urandom);
        ticks = whole ? 700 : $urandom_range(2, 60);
        n     = 0;
        send_item(mk_item(ACT_WRITE, ADDR_SPRITE_PORT, page, 1'($urandom), 8'($urandom),
                          8'($urandom)), 1'b0, '0);
        while (n < ticks && (sprite_on || !whole))
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                send_item(rand_item(3'($urandom_range(0, 4))), 1'b0, '0);
            end
            else
            begin
                if ($urandom_range(0, 15) != 0)
                    odd = !odd;
                if ($urandom_range(0, 31) == 0)
                    base = 8'($urandom);
                send_item(mk_item(ACT_SPRITE, 16'($urandom), 8'($urandom), odd,
                                  8'($urandom), base), 1'b0, '0);
            end
            n++;
        end
    endtask

    // Result side: random hold-off per item, checked in order
    initial
    begin
        int       n;
        cbd_out_t got;
        cbd_out_t want;
        rsp.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                rx_quiet = !rx_quiet;
            n = rx_quiet ? 0 : $urandom_range(0, 7);
            if (rx_hold_req)
            begin
                n           = 150;
                rx_hold_req = 1'b0;
            end
            if (n > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
            got = rsp.payload;
            n_results++;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected", n_results));
            end
            else
            begin
                want = pending_results.pop_front();
                cmp_field("read_data",       16'(got.read_data),       16'(want.read_data));
                cmp_field("target",          16'(got.target),          16'(want.target));
                cmp_field("access_address",  got.access_address,       want.access_address);
                cmp_field("access_is_write", 16'(got.access_is_write),
                          16'(want.access_is_write));
                cmp_field("device_strobe",   16'(got.device_strobe),
                          16'(want.device_strobe));
                cmp_field("oam_write",       16'(got.oam_write),       16'(want.oam_write));
                cmp_field("oam_index",       16'(got.oam_index),       16'(want.oam_index));
                cmp_field("oam_value",       16'(got.oam_value),       16'(want.oam_value));
                cmp_field("dmc_fetch",       16'(got.dmc_fetch),       16'(want.dmc_fetch));
                cmp_field("dmc_fetch_get",   16'(got.dmc_fetch_get),
                          16'(want.dmc_fetch_get));
                cmp_field("oam_dma_busy",    16'(got.oam_dma_busy),
                          16'(want.oam_dma_busy));
                cmp_field("dmc_dma_busy",    16'(got.dmc_dma_busy),
                          16'(want.dmc_dma_busy));
            end
            @(negedge clk);
        end
    end

    // Stimulus
    initial
    begin
        bit hold_done;
        int k;
        int i;
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.payload = '0;
        n_errors    = 0;
        n_results   = 0;
        n_counted   = 0;
        tx_quiet    = 1'b0;
        rx_quiet    = 1'b0;
        rx_hold_req = 1'b0;
        hold_done   = 1'b0;
        bus_hold    = '0;
        last_rd_addr = '0;
        copy_page   = '0;
        copy_count  = '0;
        copy_byte   = '0;
        sprite_on   = 1'b0;
        sample_on   = 1'b0;
        halt_wait   = 1'b0;
        for (i = 0; i < RAM_BYTES; i++)
            ram_image[i] = '0;

        // Directed: reset contents, mirrors, decode edges, open bus merges
        dir_rows.push_back('{mk_item(ACT_READ, 16'h0000, 8'h00, 1'b0, 8'hA5, 8'h00), 1'b1,
                             bus_res(8'h00, TGT_RAM, 16'h0000, 1'b0, 1'b0)});
        dir_rows.push_back('{mk_item(ACT_WRITE, 16'h0000, 8'hFF, 1'b0, 8'h00, 8'h00), 1'b1,
                             bus_res(8'h00, TGT_RAM, 16'h0000, 1'b0, 1'b0)});
        dir_rows.push_back('{mk_item(ACT_READ, 16'h1800, 8'h00, 1'b1, 8'h00, 8'hFF), 1'b0, '0});
        dir_rows.push_back('{mk_item(ACT_WRITE, 16'h1FFF, 8'h5A, 1'b0, 8'h00, 8'h00), 1'b0, '0});
        dir_rows.push_back('{mk_item(ACT_READ, 16'h07FF, 8'h00, 1'b0, 8'hFF, 8'h00), 1'b0, '0});
        dir_rows.push_back('{mk_item(ACT_READ, 16'h2000, 8'h00, 1'b0, 8'h3C, 8'h00), 1'b1,
                             bus_res(8'h3C, TGT_VIDEO, 16'h2000, 1'b0, 1'b1)});
        dir_rows.push_back('{mk_item(ACT_WRITE, 16'h3FFF, 8'h00, 1'b0, 8'hFF, 8'h00), 1'b0, '0});
        dir_rows.push_back('{mk_item(ACT_READ, 16'h4000, 8'h00, 1'b0, 8'hFF, 8'h00), 1'b1,
                             bus_res(8'h00, TGT_NONE, 16'h4000, 1'b0, 1'b0)});
        dir_rows.push_back('{mk_item(ACT_READ, 16'h4018, 8'h00, 1'b0, 8'hFF, 8'h00), 1'b0, '0});
        dir_rows.push_back('{mk_item(ACT_READ, 16'h5FFF, 8'h00, 1'b0, 8'hFF, 8'h00), 1'b0, '0});
        dir_rows.push_back('{mk_item(ACT_WRITE, 16'h4017, 8'h20, 1'b0, 8'h00, 8'h00), 1'b0, '0});
        dir_rows.push_back('{mk_item(ACT_READ, 16'h4015, 8'h00, 1'b0, 8'h00, 8'h00), 1'b0, '0});
        dir_rows.push_back('{mk_item(ACT_PEEK, 16'h4016, 8'h00, 1'b0, 8'hFF, 8'h00), 1'b0, '0});
        dir_rows.push_back('{mk_item(ACT_READ, 16'h4016, 8'h00, 1'b0, 8'h00, 8'h00), 1'b0, '0});
        dir_rows.push_back('{mk_item(ACT_READ, 16'h4017, 8'h00, 1'b0, 8'h1F, 8'h00), 1'b0, '0});
        dir_rows.push_back('{mk_item(ACT_READ, 16'h4014, 8'h00, 1'b0, 8'h77, 8'h00), 1'b0, '0});
        dir_rows.push_back('{mk_item(ACT_WRITE, 16'h5FFE, 8'h11, 1'b0, 8'h00, 8'h00), 1'b0, '0});
        dir_rows.push_back('{mk_item(ACT_WRITE, 16'h5FFF, 8'h22, 1'b0, 8'h00, 8'h00), 1'b0, '0});
        dir_rows.push_back('{mk_item(ACT_READ, 16'hFFFF, 8'h00, 1'b0, 8'h81, 8'h00), 1'b0, '0});
        dir_rows.push_back('{mk_item(ACT_WRITE, 16'h4016, 8'h01, 1'b0, 8'h00, 8'h00), 1'b0, '0});
        dir_rows.push_back('{mk_item(ACT_WRITE, 16'h4015, 8'h0F, 1'b0, 8'h00, 8'h00), 1'b0, '0});
        dir_rows.push_back('{mk_item(ACT_UNUSED, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 8'hFF), 1'b1,
                             bus_res(8'h00, TGT_NONE, 16'h0000, 1'b0, 1'b0)});
        dir_rows.push_back('{mk_item(ACT_SPRITE, 16'h0000, 8'h00, 1'b0, 8'hFF, 8'h10), 1'b1,
                             bus_res(8'h00, TGT_NONE, 16'h0000, 1'b0, 1'b0)});
        dir_rows.push_back('{mk_item(ACT_SAMPLE, 16'h0000, 8'h00, 1'b1, 8'hFF, 8'h00), 1'b1,
                             bus_res(8'h00, TGT_NONE, 16'h0000, 1'b0, 1'b0)});
        dir_rows.push_back('{mk_item(ACT_WRITE, 16'h4015, 8'hF0, 1'b0, 8'h00, 8'h00), 1'b0, '0});

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[j])
            send_item(dir_rows[j].stim, dir_rows[j].typed, dir_rows[j].want);
        drain();

        // Random: one whole sprite copy first, then mixed traffic
        n_counted = 0;
        sprite_copy(1'b1);
        while (n_counted < RANDOM_ITEMS)
        begin
            if (!hold_done && n_counted > RANDOM_ITEMS / 2)
            begin
                // long result stall while items keep coming
                hold_done   = 1'b1;
                rx_hold_req = 1'b1;
                tx_quiet    = 1'b1;
            end
            k = $urandom_range(0, 19);
            if (k < 9)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(rand_item(3'($urandom_range(0, 7))), 1'b0, '0);
                    else
                        send_item(rand_item(($urandom_range(0, 4) < 2) ? ACT_READ :
                                            ($urandom_range(0, 1) ? ACT_PEEK : ACT_WRITE)),
                                  1'b0, '0);
                end
            end
            else if (k < 13)
            begin
                sprite_copy($urandom_range(0, 5) == 0);
            end
            else if (k < 15)
            begin
                repeat ($urandom_range(1, 12))
                    send_item(mk_item(ACT_SAMPLE, 16'($urandom), 8'($urandom), 1'($urandom),
                                      8'($urandom), 8'($urandom)), 1'b0, '0);
            end
            else if (k < 19)
            begin
                // work RAM traffic across the mirrors
                repeat ($urandom_range(2, 12))
                    send_item(mk_item($urandom_range(0, 1) ? ACT_WRITE :
                                      ($urandom_range(0, 3) == 0 ? ACT_PEEK : ACT_READ),
                                      16'($urandom_range(0, 16'h1FFF)), 8'($urandom),
                                      1'($urandom), 8'($urandom), 8'($urandom)), 1'b0, '0);
            end
            else
            begin
                drain();
            end
        end

        req.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (10) @(posedge clk);
        if (n_errors == 0)
            $display("cpu_bus_decoder_with_oam_dma test passed");
        else
            $display("cpu_bus_decoder_with_oam_dma test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("cpu_bus_decoder_with_oam_dma test failed");
        $finish;
    end

endmodule
